// ===== rtl/core/rspenc_pkg.sv =====
package rspenc_pkg;

   localparam int MAX_PARITY   = 32;
   localparam int RESET_LENGTH = 10;
   localparam int CSR_W        = 6;
   localparam logic [8:0] FIELD_POLY = 9'h11D;

   typedef struct packed {
      logic rem_step;
      logic rem_clear;
      logic gen_clear;
      logic gen_step;
      logic out_load;
      logic out_shift;
   } ctrl_type;

   function automatic logic [7:0] gf_xtime(input logic [7:0] a);
      gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY[7:0] : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] sh;
      acc = 8'h00;
      sh  = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ sh;
         end
         sh = gf_xtime(sh);
      end
      gf_mul = acc;
   endfunction

endpackage

// ===== rtl/core/rspenc_req_if.sv =====
interface rspenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       message_end;

   modport source (output valid, output message_byte, output message_end, input ready);
   modport sink (input valid, input message_byte, input message_end, output ready);
endinterface

// ===== rtl/core/rspenc_rsp_if.sv =====
interface rspenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] parity_byte;
   logic       parity_last;

   modport source (output valid, output parity_byte, output parity_last, input ready);
   modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface

// ===== rtl/core/rspenc_csr_if.sv =====
interface rspenc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rspenc_pkg::CSR_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rspenc_cell.sv =====
module rspenc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  rspenc_pkg::ctrl_type ctrl,
   input  logic [7:0]           factor,
   input  logic [7:0]           root,
   input  logic [7:0]           rem_next,
   input  logic [7:0]           gen_prev,
   input  logic [7:0]           out_next,
   output logic [7:0]           rem,
   output logic [7:0]           gen,
   output logic [7:0]           out
);

   logic [7:0] rem_ff, rem_in;
   logic [7:0] gen_ff, gen_in;
   logic [7:0] out_ff, out_in;
   logic [7:0] mul_a, mul_b, prod, rem_update;

   // one multiplier per cell, shared by generator build and message update
   assign mul_a      = ctrl.gen_step ? gen_prev : gen_ff;
   assign mul_b      = ctrl.gen_step ? root : factor;
   assign prod       = rspenc_pkg::gf_mul(mul_a, mul_b);
   assign rem_update = rem_next ^ prod;

   always_comb begin
      rem_in = rem_ff;
      if (ctrl.rem_clear) begin
         rem_in = 8'h00;
      end else if (ctrl.rem_step) begin
         rem_in = rem_update;
      end
   end

   always_comb begin
      gen_in = gen_ff;
      if (ctrl.gen_clear) begin
         gen_in = 8'h00;
      end else if (ctrl.gen_step) begin
         gen_in = gen_ff ^ prod;
      end
   end

   always_comb begin
      out_in = out_ff;
      if (ctrl.out_load) begin
         out_in = rem_update;
      end else if (ctrl.out_shift) begin
         out_in = out_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 8'h00;
         gen_ff <= 8'h00;
      end else begin
         rem_ff <= rem_in;
         gen_ff <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rem = rem_ff;
   assign gen = gen_ff;
   assign out = out_ff;

endmodule

// ===== rtl/core/reed_solomon_parity_encoder_unit.sv =====
// parity bytes start in the cycle after the request marked last is accepted, if the length is nonzero
// throughput: one message byte per cycle outside a rebuild; parity bytes leave while
//    the next message streams in; a request marked last also waits on pending parity
// a length write (and reset) rebuilds the generator, one root per cycle, with requests
//    held off meanwhile
// synchronous active-high reset: length ten, remainder zero, output empty
module reed_solomon_parity_encoder_unit #(
   parameter int MAX_PARITY = rspenc_pkg::MAX_PARITY
) (
   input  logic         clock,
   input  logic         reset,
   rspenc_req_if.sink   req,
   rspenc_rsp_if.source rsp,
   rspenc_csr_if.sink   csr
);

   localparam int LEN_W = $clog2(MAX_PARITY + 1);
   localparam int RESET_LEN =
      (rspenc_pkg::RESET_LENGTH > MAX_PARITY) ? MAX_PARITY : rspenc_pkg::RESET_LENGTH;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] build_cnt_ff, build_cnt_in;
   logic [LEN_W-1:0] out_cnt_ff, out_cnt_in;
   logic [7:0]       root_ff, root_in;
   logic [LEN_W-1:0] len_sat;

   logic             gen_busy, out_free, req_take, rsp_take, csr_take, load;
   logic [7:0]       factor;
   rspenc_pkg::ctrl_type ctrl;

   logic [7:0] rem_w [0:MAX_PARITY];
   logic [7:0] gen_w [0:MAX_PARITY];
   logic [7:0] out_w [0:MAX_PARITY];

   assign len_sat = (int'(csr.data) > MAX_PARITY) ? LEN_W'(MAX_PARITY) : LEN_W'(csr.data);

   assign gen_busy = build_cnt_ff != '0;
   assign rsp_take = rsp.valid && rsp.ready;
   assign out_free = (out_cnt_ff == '0) || ((out_cnt_ff == LEN_W'(1)) && rsp_take);
   assign csr_take = csr.valid && csr.ready;
   assign req_take = req.valid && req.ready;
   assign load     = req_take && req.message_end && (len_ff != '0);

   assign csr.ready = 1'b1;
   assign req.ready = !gen_busy && (!req.message_end || out_free);

   always_comb begin
      ctrl.rem_step  = req_take;
      ctrl.rem_clear = csr_take || (req_take && req.message_end);
      ctrl.gen_clear = csr_take;
      ctrl.gen_step  = gen_busy && !csr_take;
      ctrl.out_load  = load;
      ctrl.out_shift = rsp_take;
   end

   assign factor = req.message_byte ^ rem_w[0];

   always_comb begin
      len_in       = len_ff;
      build_cnt_in = build_cnt_ff;
      root_in      = root_ff;
      if (csr_take) begin
         len_in       = len_sat;
         build_cnt_in = len_sat;
         root_in      = 8'h01;
      end else if (gen_busy) begin
         build_cnt_in = build_cnt_ff - LEN_W'(1);
         root_in      = rspenc_pkg::gf_xtime(root_ff);
      end
   end

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (load) begin
         out_cnt_in = len_ff;
      end else if (rsp_take) begin
         out_cnt_in = out_cnt_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_W'(RESET_LEN);
         build_cnt_ff <= LEN_W'(RESET_LEN);
         root_ff      <= 8'h01;
         out_cnt_ff   <= '0;
      end else begin
         len_ff       <= len_in;
         build_cnt_ff <= build_cnt_in;
         root_ff      <= root_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

   // leading generator coefficient is one; nothing shifts in past the last cell
   assign gen_w[0]          = 8'h01;
   assign rem_w[MAX_PARITY] = 8'h00;
   assign out_w[MAX_PARITY] = 8'h00;

   for (genvar k = 0; k < MAX_PARITY; k++) begin : g_cell
      rspenc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .factor   (factor),
         .root     (root_ff),
         .rem_next (rem_w[k+1]),
         .gen_prev (gen_w[k]),
         .out_next (out_w[k+1]),
         .rem      (rem_w[k]),
         .gen      (gen_w[k+1]),
         .out      (out_w[k])
      );
   end

   assign rsp.valid       = out_cnt_ff != '0;
   assign rsp.parity_byte = out_w[0];
   assign rsp.parity_last = out_cnt_ff == LEN_W'(1);

`ifndef NO_ASSERTIONS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp.valid)
      else $error("parity not presented after final message byte");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp.parity_last && !load) |=> !rsp.valid)
      else $error("parity output continues past final byte");

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      int'(out_cnt_ff) <= MAX_PARITY)
      else $error("parity count beyond maximum");

   a_build_bound: assert property (@(posedge clock) disable iff (reset)
      int'(build_cnt_ff) <= MAX_PARITY)
      else $error("generator build count beyond maximum");
`endif

endmodule
